// File: rtl/irc_tok_pkg.sv
// Package for the IRC line tokenizer: character codes, result kinds,
// status codes, the phase type, the registered result type and the blank test.
// Depends on nothing; the top level and the checker import it.
package irc_tok_pkg;

  localparam logic [7:0] ChrColon = 8'h3A;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrVt    = 8'h0B;
  localparam logic [7:0] ChrFf    = 8'h0C;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrLowA  = 8'h61;
  localparam logic [7:0] ChrLowZ  = 8'h7A;
  localparam logic [7:0] CaseDiff = 8'h20;

  localparam logic [1:0] KindDrop    = 2'd0;
  localparam logic [1:0] KindPrefix  = 2'd1;
  localparam logic [1:0] KindCommand = 2'd2;
  localparam logic [1:0] KindParam   = 2'd3;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusBlank     = 2'd1;
  localparam logic [1:0] StatusNoCommand = 2'd2;
  localparam logic [1:0] StatusEmptyCmd  = 2'd3;

  // Largest value the 4-bit index and count fields can show.
  localparam logic [3:0] FieldMax = 4'd15;

  typedef enum logic [2:0] {
    PhStart   = 3'd0,
    PhPrefix  = 3'd1,
    PhCommand = 3'd2,
    PhPStart  = 3'd3,
    PhParam   = 3'd4,
    PhTrail   = 3'd5,
    PhDrop    = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [3:0] param_index;
    logic       param_close;
    logic       line_done;
    logic [1:0] status;
    logic [3:0] param_count;
  } result_t;

  // Whitespace as the line grammar sees it.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChrSpace) || (c == ChrTab) || (c == ChrLf) ||
           (c == ChrCr) || (c == ChrFf) || (c == ChrVt);
  endfunction

endpackage

// File: rtl/irc_tok_if.sv
// Valid/ready channel interfaces for the IRC line tokenizer: one for the
// incoming character beats and one for the result beats.
// Depends on nothing.
interface irc_tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_line;

  modport source (output valid, output in_byte, output end_of_line, input ready);
  modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface irc_tok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [3:0] param_index;
  logic       param_close;
  logic       line_done;
  logic [1:0] status;
  logic [3:0] param_count;

  modport source (output valid, output out_byte, output out_kind, output param_index,
                  output param_close, output line_done, output status,
                  output param_count, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input param_index,
                  input param_close, input line_done, input status,
                  input param_count, output ready);
endinterface

// File: rtl/irc_line_tokenizer_top.sv
// Top level of the IRC line tokenizer: input register, tokenizer state
// machine and result register. Depends on irc_tok_pkg and the channel
// interfaces in irc_tok_if.sv.
//
//   Channel   Direction  Beat payload
//   in_i      sink       in_byte, end_of_line
//   out_o     source     out_byte, out_kind, param_index, param_close,
//                        line_done, status, param_count
//
// Every input beat yields exactly one result beat via the input register and
// then the result register. One beat is accepted per clock when not stalled.
// The tokenizer state advances when a beat moves from the input register to
// the result register, so the whole decision is one short step of logic.
// A stalled output holds its beat; the input register keeps taking a beat
// as long as the result register can empty, so at most two beats wait.
// Reset returns the state machine to the start of a line and empties both
// registers.
module irc_line_tokenizer_top
  import irc_tok_pkg::*;
#(
  parameter int unsigned MAX_PARAMS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  irc_tok_in_if.sink           in_i,
  irc_tok_out_if.source        out_o
);

  // The parameter counter must hold MAX_PARAMS itself.
  localparam int unsigned CntW = $clog2(MAX_PARAMS + 1);
  // Width wide enough for both the counter and the 4-bit output fields.
  localparam int unsigned SatW = (CntW > 4) ? CntW : 4;

  // Clamps a parameter number to what the 4-bit fields can carry.
  function automatic logic [3:0] sat_field(input logic [SatW-1:0] v);
    return (v > SatW'(FieldMax)) ? FieldMax : v[3:0];
  endfunction

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_eol_q;

  // Result register.
  logic       out_valid_q, out_valid_d;
  result_t    res_q, res_d;

  // Line state.
  phase_e          phase_q, phase_d;
  logic            blank_q, blank_d;
  logic            cmd_seen_q, cmd_seen_d;
  logic            cmd_err_q, cmd_err_d;
  logic [CntW-1:0] found_q, found_d;

  logic in_take;
  logic out_free;
  logic advance;

  // The result register can take a beat when it is empty or being read.
  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Tokenizer decision for the beat in the input register.
  always_comb begin
    phase_e          ph;
    logic            skip;
    logic [CntW-1:0] cnt_inc;
    logic            err_v;
    logic [1:0]      st_v;

    phase_d    = phase_q;
    blank_d    = blank_q;
    cmd_seen_d = cmd_seen_q;
    cmd_err_d  = cmd_err_q;
    found_d    = found_q;
    res_d      = '0;
    ph         = phase_q;
    skip       = 1'b0;
    cnt_inc    = found_q;
    err_v      = cmd_err_q;
    st_v       = StatusOk;

    if (s1_eol_q) begin
      // An open normal or trailing parameter is closed by the end of line.
      if ((phase_q == PhParam) || (phase_q == PhTrail)) begin
        res_d.param_index = sat_field(SatW'(found_q) - SatW'(1));
        res_d.param_close = 1'b1;
      end
      if (((phase_q == PhStart) || (phase_q == PhCommand)) && !cmd_seen_q) begin
        err_v = 1'b1;
      end
      if (blank_q) begin
        st_v = StatusBlank;
      end else if (phase_q == PhPrefix) begin
        st_v = StatusNoCommand;
      end else if (err_v) begin
        st_v = StatusEmptyCmd;
      end
      res_d.line_done = 1'b1;
      res_d.status    = st_v;
      res_d.param_count = (st_v == StatusOk) ? sat_field(SatW'(found_q)) : 4'd0;
      // Ready for the next line.
      phase_d    = PhStart;
      blank_d    = 1'b1;
      cmd_seen_d = 1'b0;
      cmd_err_d  = 1'b0;
      found_d    = '0;
    end else begin
      if (!is_blank(s1_byte_q)) begin
        blank_d = 1'b0;
      end
      if (phase_q == PhStart) begin
        if (s1_byte_q == ChrColon) begin
          // Leading colon opens the prefix and is dropped.
          phase_d = PhPrefix;
          skip    = 1'b1;
        end else begin
          ph      = PhCommand;
          phase_d = PhCommand;
        end
      end
      if (ph == PhPStart) begin
        cnt_inc = found_q + CntW'(1);
      end
      if (!skip) begin
        unique case (ph)
          PhPrefix: begin
            if (s1_byte_q == ChrSpace) begin
              phase_d = PhCommand;
            end else begin
              res_d.out_byte = s1_byte_q;
              res_d.out_kind = KindPrefix;
            end
          end
          PhCommand: begin
            if (s1_byte_q == ChrSpace) begin
              if (!cmd_seen_q) begin
                cmd_err_d = 1'b1;
              end
              phase_d = PhPStart;
            end else begin
              res_d.out_byte = ((s1_byte_q >= ChrLowA) && (s1_byte_q <= ChrLowZ)) ?
                               (s1_byte_q - CaseDiff) : s1_byte_q;
              res_d.out_kind = KindCommand;
              cmd_seen_d     = 1'b1;
            end
          end
          PhPStart, PhParam: begin
            found_d           = cnt_inc;
            res_d.param_index = sat_field(SatW'(cnt_inc) - SatW'(1));
            if ((ph == PhPStart) && (s1_byte_q == ChrColon)) begin
              // Trailing parameter: the colon itself is dropped.
              phase_d = PhTrail;
            end else if (s1_byte_q == ChrSpace) begin
              res_d.param_close = 1'b1;
              phase_d = (cnt_inc >= CntW'(MAX_PARAMS)) ? PhDrop : PhPStart;
            end else begin
              res_d.out_byte = s1_byte_q;
              res_d.out_kind = KindParam;
              phase_d        = PhParam;
            end
          end
          PhTrail: begin
            res_d.out_byte    = s1_byte_q;
            res_d.out_kind    = KindParam;
            res_d.param_index = sat_field(SatW'(found_q) - SatW'(1));
          end
          default: begin
            // Past the parameter limit every byte is dropped.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhStart;
      blank_q    <= 1'b1;
      cmd_seen_q <= 1'b0;
      cmd_err_q  <= 1'b0;
      found_q    <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      blank_q    <= blank_d;
      cmd_seen_q <= cmd_seen_d;
      cmd_err_q  <= cmd_err_d;
      found_q    <= found_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.in_byte;
      s1_eol_q  <= in_i.end_of_line;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = res_q.out_byte;
  assign out_o.out_kind    = res_q.out_kind;
  assign out_o.param_index = res_q.param_index;
  assign out_o.param_close = res_q.param_close;
  assign out_o.line_done   = res_q.line_done;
  assign out_o.status      = res_q.status;
  assign out_o.param_count = res_q.param_count;

endmodule

// File: rtl/irc_tok_checker.sv
// Port-level checks for the IRC line tokenizer and the bind that attaches
// them to irc_line_tokenizer_top. Depends on irc_tok_pkg.
module irc_tok_checker
  import irc_tok_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] out_kind_i,
  input logic [3:0] param_index_i,
  input logic       param_close_i,
  input logic       line_done_i,
  input logic [1:0] status_i,
  input logic [3:0] param_count_i
);

  // A stalled result beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
    $stable(out_kind_i) && $stable(line_done_i) && $stable(status_i))
    else $error("result beat changed while stalled");

  // A count is reported only on a clean end of line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (!line_done_i || (status_i != StatusOk)) |-> param_count_i == 4'd0)
    else $error("parameter count outside a clean end of line");

  // Dropped bytes and the end-of-line beat carry no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_kind_i == KindDrop) || line_done_i) |->
    (out_byte_i == 8'd0) && ((out_kind_i == KindDrop) || !line_done_i))
    else $error("character on a dropped or end-of-line beat");

  // Prefix and command bytes belong to no parameter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_kind_i == KindPrefix) || (out_kind_i == KindCommand)) |->
    (param_index_i == 4'd0) && !param_close_i && !line_done_i)
    else $error("prefix or command byte tagged with a parameter");

endmodule

bind irc_line_tokenizer_top irc_tok_checker u_irc_tok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .out_kind_i    (out_o.out_kind),
  .param_index_i (out_o.param_index),
  .param_close_i (out_o.param_close),
  .line_done_i   (out_o.line_done),
  .status_i      (out_o.status),
  .param_count_i (out_o.param_count)
);
